@@ hw/rtl/mhd_pkg.sv @@
`timescale 1ns / 1ps

package mhd_pkg;

  // Channel count and counter width of the filter
  localparam int NUM_CHANNELS = 8;
  localparam int COUNT_BITS   = 4;

  // Fixed port field widths
  localparam int RAW_W  = 8;
  localparam int OUT_W  = 8;
  localparam int CFG_W  = 4;
  localparam int MASK_W = 8;
  localparam int DATA_W = 8;
  localparam int IDX_W  = 2;

  // Compare width wide enough for both a counter and a threshold register
  localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((1 << COUNT_BITS) - 1);

  // Reset values of the register file
  localparam logic [CFG_W-1:0]  RST_COUNT_LIMIT = CFG_W'(11);
  localparam logic [CFG_W-1:0]  RST_ON_THRESH   = CFG_W'(10);
  localparam logic [CFG_W-1:0]  RST_OFF_THRESH  = CFG_W'(8);
  localparam logic [MASK_W-1:0] RST_INVERT_MASK = MASK_W'(27);

  typedef enum logic [IDX_W-1:0] {
    REG_COUNT_LIMIT = 2'd0,
    REG_ON_THRESH   = 2'd1,
    REG_OFF_THRESH  = 2'd2,
    REG_INVERT_MASK = 2'd3
  } mhd_reg_e;

  // Shared thresholds seen by every channel
  typedef struct packed {
    logic [CMP_W-1:0] ceiling;
    logic [CMP_W-1:0] on_thresh;
    logic [CMP_W-1:0] off_thresh;
  } mhd_thresh_t;

endpackage

@@ hw/rtl/mhd_cfg_regs.sv @@
`timescale 1ns / 1ps

module mhd_cfg_regs
  import mhd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_index,
  input  logic [DATA_W-1:0] wr_data,
  output mhd_thresh_t       thresh,
  output logic [MASK_W-1:0] invert_mask
);

  logic [CFG_W-1:0] count_limit;
  logic [CFG_W-1:0] on_threshold;
  logic [CFG_W-1:0] off_threshold;
  logic [CMP_W-1:0] limit_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_limit   <= RST_COUNT_LIMIT;
      on_threshold  <= RST_ON_THRESH;
      off_threshold <= RST_OFF_THRESH;
      invert_mask   <= RST_INVERT_MASK;
    end else if (wr_en) begin
      unique case (mhd_reg_e'(wr_index))
        REG_COUNT_LIMIT: count_limit   <= wr_data[CFG_W-1:0];
        REG_ON_THRESH:   on_threshold  <= wr_data[CFG_W-1:0];
        REG_OFF_THRESH:  off_threshold <= wr_data[CFG_W-1:0];
        REG_INVERT_MASK: invert_mask   <= wr_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Ceiling is clipped to what the counter can hold
  assign limit_ext          = CMP_W'(count_limit);
  assign thresh.ceiling     = (limit_ext < COUNT_MAX) ? limit_ext : COUNT_MAX;
  assign thresh.on_thresh   = CMP_W'(on_threshold);
  assign thresh.off_thresh  = CMP_W'(off_threshold);

endmodule

@@ hw/rtl/mhd_channel.sv @@
`timescale 1ns / 1ps

module mhd_channel
  import mhd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        sample,
  input  mhd_thresh_t thresh,
  output logic        level_next
);

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic                  level;
  logic [CMP_W-1:0]      count_ext;
  logic [CMP_W-1:0]      next_ext;

  assign count_ext = CMP_W'(count);
  assign next_ext  = CMP_W'(count_next);

  always_comb begin
    count_next = count;
    level_next = level;
    if (sample) begin
      // no clamp when the ceiling was lowered under the current count
      if (count_ext < thresh.ceiling) count_next = count + COUNT_BITS'(1);
      if (next_ext >= thresh.on_thresh) level_next = 1'b1;
    end else begin
      if (count != '0) count_next = count - COUNT_BITS'(1);
      if (next_ext <= thresh.off_thresh) level_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      level <= 1'b0;
    end else if (en) begin
      count <= count_next;
      level <= level_next;
    end
  end

`ifndef ASSERT_OFF
  a_low_not_up: assert property (@(posedge clk) disable iff (rst)
    en && !sample |=> count <= $past(count))
    else $error("count rose on a low sample");

  a_high_not_down: assert property (@(posedge clk) disable iff (rst)
    en && sample |=> count >= $past(count))
    else $error("count fell on a high sample");

  a_set_on_high: assert property (@(posedge clk) disable iff (rst)
    $rose(level) |-> $past(en && sample))
    else $error("level set without a high sample");
`endif

endmodule

@@ hw/rtl/multichannel_hysteresis_debounce_unit.sv @@
`timescale 1ns / 1ps

// Multichannel integrating debounce filter with hysteresis. Each input
// transaction carries one raw sample bit per channel; every channel runs a
// saturating up/down counter (up on high, down on low, held to the range
// zero..min(count_limit, counter max), though a count above a lowered ceiling
// is not clamped) and a level that is set when a high sample leaves the
// counter at or above on_threshold and cleared when a low sample leaves it at
// or below off_threshold. Levels are XORed with invert_mask and returned as
// one output transaction per input transaction. Rate: one transaction per
// cycle sustained; the sample register feeds the result register, and the
// channel counters update as a sample moves into it. Only out_ready throttles
// the flow. Configuration writes are always taken (cfg_ready is tied high)
// and must only be issued while the filter is empty.

module multichannel_hysteresis_debounce_unit
  import mhd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // sample channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [RAW_W-1:0]  raw_samples,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  filtered_levels,
  // register write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data
);

  localparam int OUT_CH = (NUM_CHANNELS < OUT_W) ? NUM_CHANNELS : OUT_W;

  mhd_thresh_t              thresh;
  logic [MASK_W-1:0]        invert_mask;

  // sample register
  logic                     s0_valid;
  logic [RAW_W-1:0]         s0_samples;
  logic                     s0_advance;
  logic                     out_free;

  logic [NUM_CHANNELS-1:0]  ch_sample;
  logic [NUM_CHANNELS-1:0]  ch_level_next;
  logic [OUT_W-1:0]         levels_next;

  assign cfg_ready = 1'b1;

  mhd_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (cfg_valid & cfg_ready),
    .wr_index    (cfg_index),
    .wr_data     (cfg_data),
    .thresh      (thresh),
    .invert_mask (invert_mask)
  );

  // Handshake: result register frees up when it's empty or being drained
  assign out_free   = !out_valid || out_ready;
  assign s0_advance = s0_valid && out_free;
  assign in_ready   = !s0_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_samples <= raw_samples;
    end
  end

  // Channels past the input width always see a low sample
  genvar gi;
  generate
    for (gi = 0; gi < NUM_CHANNELS; gi++) begin : g_ch
      if (gi < RAW_W) begin : g_in
        assign ch_sample[gi] = s0_samples[gi];
      end else begin : g_pad
        assign ch_sample[gi] = 1'b0;
      end

      mhd_channel u_ch (
        .clk        (clk),
        .rst        (rst),
        .en         (s0_advance),
        .sample     (ch_sample[gi]),
        .thresh     (thresh),
        .level_next (ch_level_next[gi])
      );
    end
  endgenerate

  // Output bits: the level after this sample's update, then the invert mask.
  // Loaded into the result register on the same edge the channels update.
  always_comb begin
    levels_next = '0;
    for (int i = 0; i < OUT_CH; i++) begin
      levels_next[i] = ch_level_next[i] ^ invert_mask[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s0_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_advance) begin
      filtered_levels <= levels_next;
    end
  end

`ifndef ASSERT_OFF
  a_adv_gives_result: assert property (@(posedge clk) disable iff (rst)
    s0_advance |=> out_valid)
    else $error("sample moved on without a result");

  a_stall_keeps_sample: assert property (@(posedge clk) disable iff (rst)
    s0_valid && !s0_advance |=> s0_valid && $stable(s0_samples))
    else $error("stalled sample lost");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered_levels))
    else $error("result register overwritten before it was taken");
`endif

endmodule

@@ dv/multichannel_hysteresis_debounce_unit_tb.sv @@
`timescale 1ns / 1ps

module multichannel_hysteresis_debounce_unit_tb;
  import mhd_pkg::*;

  localparam int GAP_MAX        = 10;   // longest idle draw on either side
  localparam int WATCHDOG_LIMIT = 500;  // cycles with no transaction at all
  localparam int ITEM_TARGET    = 1000; // stimulus stops once this many samples went in
  localparam int DRAIN_CYCLES   = 8;    // pipeline is two deep; this is plenty
  localparam int REG_MAX        = (1 << CFG_W) - 1;
  localparam int PLAN_LEN       = 36;

  // How a random phase programs the shared thresholds
  typedef enum int {
    SET_RANDOM         = 0,
    SET_EXTREME        = 1,
    SET_ON_ABOVE_LIMIT = 2,
    SET_ORDERED        = 3
  } setting_e;

  // How a random phase shapes the raw sample stream
  typedef enum int {
    PAT_NOISE  = 0,  // every bit random every tick
    PAT_STICKY = 1,  // bits flip now and then
    PAT_HOLD   = 2,  // whole word held for a run of ticks
    PAT_GLITCH = 3   // long stable target with single-bit bounces
  } pattern_e;

  // One row of the directed sequence: either a register write or a sample.
  // Samples with 'known' set carry an expected value typed in by hand.
  typedef struct {
    bit                 is_wr;
    mhd_reg_e           idx;
    logic [DATA_W-1:0]  data;
    bit                 known;
    logic [OUT_W-1:0]   want;
  } plan_row_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [RAW_W-1:0]  raw_samples;
  logic              out_valid;
  logic              out_ready;
  logic [OUT_W-1:0]  filtered_levels;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index;
  logic [DATA_W-1:0] cfg_data;

  // Shadow copy of the filter: registers and per-channel state
  logic [CFG_W-1:0]      lim_reg;
  logic [CFG_W-1:0]      on_reg;
  logic [CFG_W-1:0]      off_reg;
  logic [MASK_W-1:0]     mask_reg;
  logic [COUNT_BITS-1:0] chan_count [NUM_CHANNELS];
  bit                    chan_level [NUM_CHANNELS];

  logic [OUT_W-1:0] expected_levels [$];
  logic [OUT_W-1:0] oldest_levels;
  plan_row_t        plan [PLAN_LEN];

  int mismatches   = 0;
  int items_sent   = 0;
  int stall_cycles = 0;
  bit quiet        = 1'b0;  // when set, neither side idles

  multichannel_hysteresis_debounce_unit dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .raw_samples     (raw_samples),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .filtered_levels (filtered_levels),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Advance every channel by one tick and return the packed, masked levels.
  function automatic logic [OUT_W-1:0] debounce_step(input logic [RAW_W-1:0] raw);
    logic [OUT_W-1:0] packed_lv;
    int ceil_v;
    int cnt;
    bit hi;
    packed_lv = '0;
    // ceiling is the register clipped to what the counter can hold
    ceil_v = int'(lim_reg);
    if (ceil_v > int'(COUNT_MAX)) ceil_v = int'(COUNT_MAX);
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      cnt = int'(chan_count[ch]);
      hi  = (ch < RAW_W) ? raw[ch] : 1'b0;
      if (hi) begin
        // a count left above a lowered ceiling is neither bumped nor clamped
        if (cnt < ceil_v) cnt++;
        if (cnt >= int'(on_reg)) chan_level[ch] = 1'b1;
      end else begin
        if (cnt > 0) cnt--;
        if (cnt <= int'(off_reg)) chan_level[ch] = 1'b0;
      end
      chan_count[ch] = COUNT_BITS'(cnt);
      if (ch < OUT_W) packed_lv[ch] = chan_level[ch] ^ mask_reg[ch];
    end
    return packed_lv;
  endfunction

  // Register value in the low bits, junk above it (ignored by the block)
  function automatic logic [DATA_W-1:0] with_noise(input int v);
    logic [DATA_W-1:0] d;
    d = DATA_W'($urandom);
    d[CFG_W-1:0] = CFG_W'(v);
    return d;
  endfunction

  function automatic plan_row_t smp(input logic [RAW_W-1:0] v);
    plan_row_t r;
    r.is_wr = 1'b0;
    r.idx   = REG_COUNT_LIMIT;
    r.data  = v;
    r.known = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic plan_row_t smp_known(input logic [RAW_W-1:0] v,
                                          input logic [OUT_W-1:0] w);
    plan_row_t r;
    r = smp(v);
    r.known = 1'b1;
    r.want  = w;
    return r;
  endfunction

  function automatic plan_row_t reg_wr(input mhd_reg_e idx, input logic [DATA_W-1:0] d);
    plan_row_t r;
    r = smp('0);
    r.is_wr = 1'b1;
    r.idx   = idx;
    r.data  = d;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] want);
    mismatches++;
    $display("%0t: %s: filtered_levels got %h, expected %h", $time, what, got, want);
  endtask

  // Push one sample transaction, record its expected result, then idle a bit.
  // Valid is dropped only when a gap follows, so back-to-back samples never
  // see valid lowered and raised in the same step.
  task automatic send_sample(input logic [RAW_W-1:0] v, input bit known,
                             input logic [OUT_W-1:0] want);
    logic [OUT_W-1:0] predicted;
    int gap;
    in_valid    <= 1'b1;
    raw_samples <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = debounce_step(v);
    expected_levels.push_back(known ? want : predicted);
    items_sent++;
    gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Registers may only change with the pipe empty. Every sample yields a
  // result, so an empty expectation queue means the block holds nothing.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
  endtask

  // Caller lowers cfg_valid after the last write of a batch.
  task automatic write_reg(input mhd_reg_e idx, input logic [DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_COUNT_LIMIT: lim_reg  = d[CFG_W-1:0];
      REG_ON_THRESH:   on_reg   = d[CFG_W-1:0];
      REG_OFF_THRESH:  off_reg  = d[CFG_W-1:0];
      REG_INVERT_MASK: mask_reg = d[MASK_W-1:0];
      default: ;
    endcase
  endtask

  // Result side: ready drops for a random number of cycles after each
  // accepted result, except in quiet phases.
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Every accepted result is matched against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_levels.size() == 0) begin
        report_mismatch("result with nothing pending", filtered_levels, 'x);
      end else begin
        oldest_levels = expected_levels.pop_front();
        if (filtered_levels !== oldest_levels)
          report_mismatch("level mismatch", filtered_levels, oldest_levels);
      end
    end
  end

  // Hang detector: any transaction on any channel resets the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    setting_e          set_mode;
    pattern_e          pat;
    logic [RAW_W-1:0]  word;
    logic [RAW_W-1:0]  target;
    int                hold;
    int                n_items;
    int                lim;
    int                on_t;
    int                off_t;

    rst         = 1'b1;
    in_valid    = 1'b0;
    raw_samples = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_COUNT_LIMIT;
    cfg_data    = '0;

    // shadow state matches the block's reset
    lim_reg  = RST_COUNT_LIMIT;
    on_reg   = RST_ON_THRESH;
    off_reg  = RST_OFF_THRESH;
    mask_reg = RST_INVERT_MASK;
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      chan_count[ch] = '0;
      chan_level[ch] = 1'b0;
    end

    plan = '{
      // reset settings: all levels low, so the output is the invert mask
      smp_known(8'h00, 8'h1B),
      // one high tick only reaches count 1, far below the on threshold
      smp_known(8'hFF, 8'h1B),
      // ceiling zero, on at zero, off at max, no inversion: counts sit above
      // the new ceiling, and the level simply tracks the raw bit
      reg_wr(REG_COUNT_LIMIT, 8'h00),
      reg_wr(REG_ON_THRESH,   8'h00),
      reg_wr(REG_OFF_THRESH,  8'h0F),
      reg_wr(REG_INVERT_MASK, 8'h00),
      smp_known(8'hA5, 8'hA5),
      smp_known(8'h5A, 8'h5A),
      smp_known(8'hFF, 8'hFF),
      smp_known(8'h00, 8'h00),
      // full inversion flips everything
      reg_wr(REG_INVERT_MASK, 8'hFF),
      smp_known(8'h00, 8'hFF),
      smp_known(8'hFF, 8'h00),
      // top ceiling (upper data bits must be dropped), narrow hysteresis
      reg_wr(REG_COUNT_LIMIT, 8'hFF),
      reg_wr(REG_ON_THRESH,   8'h03),
      reg_wr(REG_OFF_THRESH,  8'h01),
      reg_wr(REG_INVERT_MASK, 8'h00),
      smp(8'hFF), smp(8'hFF), smp(8'hFF), smp(8'hFF),
      smp(8'h00), smp(8'h00), smp(8'h00),
      smp(8'h0F), smp(8'hF0),
      // ceiling lowered to two, still above the live counts
      reg_wr(REG_COUNT_LIMIT, 8'h02),
      reg_wr(REG_ON_THRESH,   8'h02),
      reg_wr(REG_OFF_THRESH,  8'h00),
      smp(8'h3C), smp(8'hC3), smp(8'hFF), smp(8'h00),
      // on threshold above the ceiling: a level can never be set
      reg_wr(REG_ON_THRESH,   8'hF7),
      smp(8'hFF), smp(8'h00)
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed sequence
    for (int r = 0; r < PLAN_LEN; r++) begin
      if (plan[r].is_wr) begin
        wait_drained();
        write_reg(plan[r].idx, plan[r].data);
        if (r == PLAN_LEN - 1 || !plan[r + 1].is_wr) cfg_valid <= 1'b0;
      end else begin
        send_sample(plan[r].data, plan[r].known, plan[r].want);
      end
    end

    // Random phases: new settings, then a shaped sample stream
    word   = '0;
    target = '0;
    while (items_sent < ITEM_TARGET) begin
      // ordered hysteresis is the useful case, so it gets half the phases
      set_mode = ($urandom_range(0, 1) == 0) ? SET_ORDERED
                                             : setting_e'($urandom_range(0, 2));
      case (set_mode)
        SET_EXTREME: begin
          lim   = $urandom_range(0, 1) ? REG_MAX : 0;
          on_t  = $urandom_range(0, 1) ? REG_MAX : 0;
          off_t = $urandom_range(0, 1) ? REG_MAX : 0;
        end
        SET_ON_ABOVE_LIMIT: begin
          lim   = $urandom_range(0, REG_MAX - 1);
          on_t  = $urandom_range(lim + 1, REG_MAX);
          off_t = $urandom_range(0, REG_MAX);
        end
        SET_ORDERED: begin
          lim   = $urandom_range(2, REG_MAX);
          on_t  = $urandom_range(1, lim);
          off_t = $urandom_range(0, on_t - 1);
        end
        default: begin
          lim   = $urandom_range(0, REG_MAX);
          on_t  = $urandom_range(0, REG_MAX);
          off_t = $urandom_range(0, REG_MAX);
        end
      endcase

      wait_drained();
      quiet = ($urandom_range(0, 3) == 0);
      write_reg(REG_COUNT_LIMIT, with_noise(lim));
      write_reg(REG_ON_THRESH,   with_noise(on_t));
      write_reg(REG_OFF_THRESH,  with_noise(off_t));
      write_reg(REG_INVERT_MASK, DATA_W'($urandom));
      cfg_valid <= 1'b0;

      pat     = pattern_e'($urandom_range(0, 3));
      hold    = 0;
      n_items = $urandom_range(60, 140);
      for (int k = 0; k < n_items; k++) begin
        case (pat)
          PAT_STICKY: begin
            for (int b = 0; b < RAW_W; b++)
              if ($urandom_range(0, 7) == 0) word[b] = ~word[b];
          end
          PAT_HOLD: begin
            if (hold == 0) begin
              word = RAW_W'($urandom);
              hold = $urandom_range(1, 20);
            end
            hold--;
          end
          PAT_GLITCH: begin
            if (hold == 0) begin
              target = RAW_W'($urandom);
              hold   = $urandom_range(10, 40);
            end
            hold--;
            word = target;
            if ($urandom_range(0, 2) == 0)
              word = word ^ (RAW_W'(1) << $urandom_range(0, RAW_W - 1));
          end
          default: word = RAW_W'($urandom);
        endcase
        send_sample(word, 1'b0, '0);
      end
    end

    // Let the last results come out, then watch a few more cycles for strays
    quiet = 1'b0;
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
